### sv/mdpa_pkg.sv
package mdpa_pkg;

    // Number of accumulators; positions wrap at this power of two.
    localparam int VECTOR_LENGTH = 1024;

    typedef struct packed {
        logic [9:0]  position;
        logic [62:0] factor_a;
        logic [62:0] factor_b;
        logic        first_term;
        logic        last_term;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  out_position;
        logic [62:0] residue;
    } out_item_t;

    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [0:0] REG_FACTOR  = 1'b1;

    // Product of 63x63 operands, split in four partials of the 32-bit and 31-bit halves.
    typedef struct packed {
        logic [9:0]  position;
        logic        first_term;
        logic        last_term;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } prod_t;

    // Entry of the queue between the accumulate front and the reduce back.
    typedef struct packed {
        logic [9:0]   position;
        logic [127:0] sum;
    } red_item_t;

    function automatic logic [5:0] msb_index(input logic [62:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 1; i < 63; i++)
        begin
            if (v[i])
                n = 6'(i);
        end
        return n;
    endfunction

endpackage

### sv/mdpa_ram.sv
module mdpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

### sv/mdpa_front.sv
// Accumulate front: multiply, read accumulator, add with forwarding, write back.
module mdpa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mdpa_pkg::in_item_t  in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output mdpa_pkg::red_item_t q_data,
    output logic                q_valid,
    input  logic                q_room
);
    import mdpa_pkg::*;

    localparam int AW = $clog2(VECTOR_LENGTH);

    // Stage 1: partial products and memory read issue.
    prod_t      s1_reg;
    logic       s1_valid_reg;
    // Stage 2: product summed, read data arrives.
    logic [9:0]   s2_pos_reg;
    logic         s2_first_reg, s2_last_reg, s2_valid_reg;
    logic [127:0] s2_prod_reg;
    // Forwarded copies of the last two writes.
    logic         w1_valid_reg, w2_valid_reg;
    logic [AW-1:0] w1_addr_reg, w2_addr_reg;
    logic [127:0]  w1_data_reg, w2_data_reg;
    logic [AW-1:0] s2_rdaddr_reg;

    logic [63:0]  rd_hi, rd_lo;
    logic [127:0] base, sum;
    logic [127:0] prod;
    logic         adv;
    logic [AW-1:0] s1_addr;

    // The pipeline moves only when the queue has room for every item in flight.
    assign adv      = q_room;
    assign in_ready = adv;
    assign s1_addr  = s1_reg.position[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            w1_valid_reg <= 1'b0;
            w2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            w1_valid_reg <= s2_valid_reg;
            w2_valid_reg <= w1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.position   <= in_data.position;
            s1_reg.first_term <= in_data.first_term;
            s1_reg.last_term  <= in_data.last_term;
            s1_reg.ll <= {32'd0, in_data.factor_a[31:0]} * {32'd0, in_data.factor_b[31:0]};
            s1_reg.lh <= {32'd0, in_data.factor_a[31:0]} * {33'd0, in_data.factor_b[62:32]};
            s1_reg.hl <= {33'd0, in_data.factor_a[62:32]} * {32'd0, in_data.factor_b[31:0]};
            s1_reg.hh <= {33'd0, in_data.factor_a[62:32]} * {33'd0, in_data.factor_b[62:32]};
            s2_pos_reg    <= s1_reg.position;
            s2_first_reg  <= s1_reg.first_term;
            s2_last_reg   <= s1_reg.last_term;
            s2_rdaddr_reg <= s1_addr;
            s2_prod_reg   <= prod;
            w1_addr_reg   <= s2_rdaddr_reg;
            w1_data_reg   <= sum;
            w2_addr_reg   <= w1_addr_reg;
            w2_data_reg   <= w1_data_reg;
        end
    end

    assign prod = {64'd0, s1_reg.ll} + {32'd0, s1_reg.lh, 32'd0}
                + {32'd0, s1_reg.hl, 32'd0} + {s1_reg.hh, 64'd0};

    mdpa_ram #(.WIDTH(64), .DEPTH(VECTOR_LENGTH)) u_hi (
        .clk(clk), .wr_en(adv && s2_valid_reg), .wr_addr(s2_rdaddr_reg),
        .wr_data(sum[127:64]), .rd_en(adv), .rd_addr(s1_addr), .rd_data(rd_hi));
    mdpa_ram #(.WIDTH(64), .DEPTH(VECTOR_LENGTH)) u_lo (
        .clk(clk), .wr_en(adv && s2_valid_reg), .wr_addr(s2_rdaddr_reg),
        .wr_data(sum[63:0]), .rd_en(adv), .rd_addr(s1_addr), .rd_data(rd_lo));

    // The read was issued from stage 1 and registered in the RAM; the write of
    // the item just ahead may not be in the read data, the one before it is.
    always_comb
    begin
        base = {rd_hi, rd_lo};
        if (w2_valid_reg && w2_addr_reg == s2_rdaddr_reg)
            base = w2_data_reg;
        if (w1_valid_reg && w1_addr_reg == s2_rdaddr_reg)
            base = w1_data_reg;
        if (s2_first_reg)
            base = '0;
        sum = base + s2_prod_reg;
    end

    assign q_valid = adv && s2_valid_reg && s2_last_reg;
    assign q_data  = '{position: s2_pos_reg, sum: sum};
endmodule

### sv/mdpa_back.sv
// Reduce back: Barrett reduction pipeline with output register.
module mdpa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [62:0]         modulus,
    input  logic [63:0]         barrett_factor,
    input  mdpa_pkg::red_item_t q_data,
    input  logic                q_valid,
    output logic                q_pop,
    output mdpa_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);
    import mdpa_pkg::*;

    logic [5:0]   shamt;
    logic [127:0] shifted;
    logic         adv;
    logic [3:0]   v_reg;
    logic [9:0]   p_reg [4];
    logic [63:0]  lo_reg [4];
    logic [63:0]  c1_reg;
    logic [63:0]  pll_reg, plh_reg, phl_reg, phh_reg;
    logic [63:0]  c3_reg;
    logic [127:0] cs;
    logic [63:0]  ql_reg, qh_reg;
    logic [63:0]  r, q;

    assign adv   = !out_valid || out_ready;
    assign q_pop = adv && q_valid;
    assign shamt = msb_index(modulus);
    assign shifted = q_data.sum >> shamt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[2:0], q_valid};
            out_valid <= v_reg[3];
        end
    end

    always_comb
    begin
        cs = {64'd0, pll_reg} + {32'd0, plh_reg, 32'd0}
           + {32'd0, phl_reg, 32'd0} + {phh_reg, 64'd0};
        q  = ql_reg + {qh_reg[31:0], 32'd0};
        r  = lo_reg[3] - q;
        if (r >= {1'b0, modulus})
            r = r - {1'b0, modulus};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]  <= q_data.position;
            lo_reg[0] <= q_data.sum[63:0];
            c1_reg    <= shifted[63:0];
            for (int i = 1; i < 4; i++)
            begin
                p_reg[i]  <= p_reg[i-1];
                lo_reg[i] <= lo_reg[i-1];
            end
            pll_reg <= {32'd0, c1_reg[31:0]}  * {32'd0, barrett_factor[31:0]};
            plh_reg <= {32'd0, c1_reg[31:0]}  * {32'd0, barrett_factor[63:32]};
            phl_reg <= {32'd0, c1_reg[63:32]} * {32'd0, barrett_factor[31:0]};
            phh_reg <= {32'd0, c1_reg[63:32]} * {32'd0, barrett_factor[63:32]};
            c3_reg  <= cs[127:64];
            // Low 64 bits of c3 * modulus from two partials.
            ql_reg  <= {32'd0, c3_reg[31:0]} * {32'd0, modulus[31:0]};
            qh_reg  <= ({32'd0, c3_reg[31:0]} * {33'd0, modulus[62:32]})
                     + ({32'd0, c3_reg[63:32]} * {32'd0, modulus[31:0]});
            out_data.out_position <= p_reg[3];
            out_data.residue      <= r[62:0];
        end
    end
endmodule

### sv/mdpa_queue.sv
// Short queue between front and back. Space is reserved for items still
// inside the front pipeline, so the front stalls only on the reservation.
module mdpa_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  mdpa_pkg::red_item_t wr_data,
    input  logic                wr_en,
    output logic                room,
    output mdpa_pkg::red_item_t rd_data,
    output logic                rd_valid,
    input  logic                rd_pop
);
    import mdpa_pkg::*;

    localparam int DEPTH = 8;
    red_item_t   mem_reg [DEPTH];
    logic [2:0]  wp_reg, rp_reg;
    logic [3:0]  cnt_reg, cnt_next;

    assign rd_valid = cnt_reg != 4'd0;
    assign rd_data  = mem_reg[rp_reg];
    // Two items may still be in the front stages and one entering.
    assign room     = cnt_reg <= 4'd4;
    assign cnt_next = cnt_reg + {3'd0, wr_en} - {3'd0, rd_pop && rd_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 3'd1;
            if (rd_pop && rd_valid)
                rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

### sv/modular_dot_product_accumulator_unit.sv
// Channel   Handshake              Beat
// in        in_valid / in_ready    mdpa_pkg::in_item_t
// out       out_valid / out_ready  mdpa_pkg::out_item_t
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
// One item per cycle sustained while neither side stalls. The front runs two
// stages (partial products with the accumulator read, then add with
// forwarding and write back), the queue registers each item, and the back runs
// four stages (shift, Barrett partials, high word, low word of c3 times
// modulus) before the subtract lands in the output register. The front
// stalls while the queue holds more than four beats; the back stalls on
// out_ready. Reset sets control, the modulus to 2 and the factor to zero,
// not the accumulators.
module modular_dot_product_accumulator_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  mdpa_pkg::in_item_t  in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output mdpa_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import mdpa_pkg::*;

    logic [62:0] modulus_reg;
    logic [63:0] factor_reg;
    red_item_t   fq_data, qb_data;
    logic        fq_valid, room, qb_valid, qb_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= 63'd2;
            factor_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data[62:0];
                REG_FACTOR:  factor_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    mdpa_front u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .q_data(fq_data), .q_valid(fq_valid), .q_room(room));

    mdpa_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(fq_data), .wr_en(fq_valid), .room(room),
        .rd_data(qb_data), .rd_valid(qb_valid), .rd_pop(qb_pop));

    mdpa_back u_back (
        .clk(clk), .rst_n(rst_n), .modulus(modulus_reg), .barrett_factor(factor_reg),
        .q_data(qb_data), .q_valid(qb_valid), .q_pop(qb_pop),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready));
endmodule

### sv/mdpa_checker.sv
module mdpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input mdpa_pkg::out_item_t out_data,
    input logic                cfg_ready
);
    import mdpa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result right after reset");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid}))
        else $error("handshake signal unknown");
endmodule

bind modular_dot_product_accumulator_unit mdpa_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_ready(cfg_ready));

### test/tb_modular_dot_product_accumulator_unit.sv
`timescale 1ns / 100ps

module tb_modular_dot_product_accumulator_unit;

    import mdpa_pkg::*;

    localparam int          DEPTH       = VECTOR_LENGTH;
    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [62:0] MAX63       = {63{1'b1}};

    logic        clk;
    logic        rst_n;
    in_item_t    in_data;
    logic        in_valid;
    logic        in_ready;
    out_item_t   out_data;
    logic        out_valid;
    logic        out_ready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;

    // Shadow of the block's registers and accumulators.
    logic [62:0]  modulus_q;
    logic [63:0]  factor_q;
    logic [127:0] acc_sums [DEPTH];
    bit           acc_valid [DEPTH];

    out_item_t expected_residues [$];
    int        mismatches;
    int        idle_cycles;
    int        terms_sent;
    int        sender_idle_pct;
    int        receiver_idle_pct;
    bit        hold_on;
    int        hold_count;
    int        recent_pos;

    modular_dot_product_accumulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int top_bit(input logic [62:0] v);
        int n;
        n = 0;
        for (int i = 1; i < 63; i++)
        begin
            if (v[i])
                n = i;
        end
        return n;
    endfunction

    function automatic logic [63:0] barrett_for(input logic [62:0] m);
        logic [127:0] quotient;
        if (m == '0)
            return '0;
        quotient = (128'd1 << (64 + top_bit(m))) / {65'd0, m};
        return quotient[63:0];
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    // Accumulates one term and, on the last term, queues the reduced residue.
    task automatic accumulate_and_reduce(input in_item_t t);
        logic [127:0] sum;
        logic [127:0] wide;
        logic [63:0]  c1;
        logic [63:0]  c3;
        logic [63:0]  r;
        out_item_t    res;
        int           s;
        sum = (t.first_term ? 128'd0 : acc_sums[t.position]) +
              {65'd0, t.factor_a} * {65'd0, t.factor_b};
        acc_sums[t.position]  = sum;
        acc_valid[t.position] = 1'b1;
        if (t.last_term)
        begin
            s    = top_bit(modulus_q);
            wide = sum >> s;
            c1   = wide[63:0];
            wide = {64'd0, c1} * {64'd0, factor_q};
            c3   = wide[127:64];
            r    = sum[63:0] - c3 * {1'b0, modulus_q};
            if (r >= {1'b0, modulus_q})
                r = r - {1'b0, modulus_q};
            res.out_position = t.position;
            res.residue      = r[62:0];
            expected_residues.push_back(res);
        end
    endtask

    // Called at a rising edge; returns at the edge where the beat is taken, or later if it then idles the input.
    task automatic send_term(input logic [9:0] pos, input logic [62:0] a,
                             input logic [62:0] b, input bit first, input bit last);
        in_item_t t;
        t.position   = pos;
        t.factor_a   = a;
        t.factor_b   = b;
        t.first_term = first;
        t.last_term  = last;
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_and_reduce(t);
        terms_sent++;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_residues.size() != 0)
            @(posedge clk);
        // Terms that produce no result may still be in flight.
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MODULUS)
            modulus_q = value[62:0];
        else
            factor_q = value;
    endtask

    task automatic set_modulus(input logic [62:0] m);
        write_reg(REG_MODULUS, {1'b0, m});
        write_reg(REG_FACTOR, barrett_for(m));
    endtask

    // Operands mostly below the modulus, some anywhere in the field.
    function automatic logic [62:0] pick_operand();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return MAX63;
        if (sel == 1)
            return '0;
        if (sel < 5 || modulus_q == '0)
            return rand63();
        return rand63() % modulus_q;
    endfunction

    task automatic random_terms(input int count);
        logic [9:0] pos;
        bit         first;
        bit         last;
        for (int i = 0; i < count; i++)
        begin
            // Idle pattern follows overall progress through the run.
            if (terms_sent < 520)
            begin
                sender_idle_pct   = 16;
                receiver_idle_pct = 46;
            end
            else if (terms_sent < 1040)
            begin
                sender_idle_pct   = 46;
                receiver_idle_pct = 16;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            // Back-to-back hits on one position exercise forwarding.
            if ($urandom_range(99) < 35)
                pos = 10'(recent_pos + $urandom_range(1));
            else
                pos = 10'($urandom_range(DEPTH - 1));
            recent_pos = pos;
            first = !acc_valid[pos] || ($urandom_range(99) < 25);
            last  = $urandom_range(99) < 35;
            send_term(pos, pick_operand(), pick_operand(), first, last);
        end
    endtask

    task automatic test_directed();
        sender_idle_pct   = 16;
        receiver_idle_pct = 46;
        send_term(10'd0, '0, '0, 1'b1, 1'b1);
        send_term(10'd1023, MAX63, MAX63, 1'b1, 1'b1);
        send_term(10'h2AA, MAX63, 63'd1, 1'b1, 1'b0);
        send_term(10'h155, 63'd1, MAX63, 1'b1, 1'b0);
        send_term(10'h2AA, 63'd5, 63'd7, 1'b0, 1'b1);
        send_term(10'h155, '0, MAX63, 1'b0, 1'b1);
        // Enough maximal products to wrap the 128-bit sum.
        send_term(10'd7, MAX63, MAX63, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            send_term(10'd7, MAX63, MAX63, 1'b0, 1'b0);
        send_term(10'd7, MAX63, MAX63, 1'b0, 1'b1);
        set_modulus(MAX63);
        send_term(10'd3, MAX63 - 1, MAX63 - 1, 1'b1, 1'b1);
        send_term(10'd4, MAX63 - 1, MAX63 - 1, 1'b1, 1'b0);
        send_term(10'd4, MAX63 - 1, 63'd2, 1'b0, 1'b0);
        send_term(10'd4, MAX63, MAX63, 1'b0, 1'b1);
        send_term(10'd1023, '0, '0, 1'b0, 1'b1);
        send_term(10'd0, 63'd1, 63'd1, 1'b0, 1'b1);
    endtask

    task automatic test_large_modulus();
        set_modulus(MAX63 - 24);
        random_terms(160);
    endtask

    task automatic test_small_moduli();
        set_modulus(63'd2);
        random_terms(80);
        set_modulus(63'd3);
        random_terms(80);
    endtask

    // A wrong factor leaves sums too large for the single subtract.
    task automatic test_factor_extremes();
        write_reg(REG_MODULUS, {1'b0, rand63() | 63'h4000_0000});
        write_reg(REG_FACTOR, '1);
        random_terms(70);
        write_reg(REG_FACTOR, '0);
        random_terms(50);
    endtask

    task automatic test_degenerate_moduli();
        write_reg(REG_MODULUS, 64'd1);
        write_reg(REG_FACTOR, {$urandom, $urandom});
        random_terms(40);
        write_reg(REG_MODULUS, 64'd0);
        random_terms(40);
    endtask

    task automatic test_backpressure();
        set_modulus(rand63() | 63'd1);
        sender_idle_pct = 0;
        hold_on <= 1'b1;
        for (int i = 0; i < 120; i++)
            send_term(10'(i), pick_operand(), pick_operand(), 1'b1, 1'b1);
        hold_on <= 1'b0;
    endtask

    task automatic test_random_moduli();
        for (int k = 0; k < 6; k++)
        begin
            set_modulus(63'($urandom_range(62, 2)) == 0 ? 63'd5 :
                        (rand63() >> $urandom_range(60)) | 63'd2);
            random_terms(150);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_count = 0;
        end
        else if (hold_on && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_residues.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: position %0d residue %h",
                             out_data.out_position, out_data.residue);
            end
            else
            begin
                exp_res = expected_residues.pop_front();
                if (out_data.out_position !== exp_res.out_position ||
                    out_data.residue !== exp_res.residue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected position %0d residue %h, got %0d %h",
                                 exp_res.out_position, exp_res.residue,
                                 out_data.out_position, out_data.residue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        hold_on           = 1'b0;
        mismatches        = 0;
        idle_cycles       = 0;
        terms_sent        = 0;
        recent_pos        = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        modulus_q         = 63'd2;
        factor_q          = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            acc_sums[i]  = '0;
            acc_valid[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_large_modulus();
        test_small_moduli();
        test_factor_extremes();
        test_degenerate_moduli();
        test_backpressure();
        test_random_moduli();

        drain();
        if (expected_residues.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
sv/mdpa_pkg.sv
sv/mdpa_ram.sv
sv/mdpa_front.sv
sv/mdpa_back.sv
sv/mdpa_queue.sv
sv/modular_dot_product_accumulator_unit.sv
sv/mdpa_checker.sv
test/tb_modular_dot_product_accumulator_unit.sv
